// ----- hw/rtl/macs_pkg.sv -----
// ============================================================================
// macs_pkg
// Shared types and constants of the moving average crossover signal core:
// price and sum widths, ring addressing, action codes and register indexes.
// ============================================================================
package macs_pkg;

   // Sizing of the close ring and the price path
   localparam int MAX_WINDOW = 256;
   localparam int PRICE_BITS = 32;

   localparam int RING_AW = $clog2(MAX_WINDOW);
   localparam int BARS_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W   = PRICE_BITS + 8;
   localparam int PER_W   = 8;
   localparam int PROD_W  = SUM_W + PER_W;
   localparam int CMP_W   = (BARS_W > PER_W) ? BARS_W : PER_W;

   // Longest usable window, limited by the ring and by the period register
   localparam int PER_CAP_INT = (MAX_WINDOW - 1 > 255) ? 255 : MAX_WINDOW - 1;

   // Register reset values
   localparam int FAST_PERIOD_RST = 10;
   localparam int SLOW_PERIOD_RST = 50;

   // Configuration space
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [RING_AW-1:0]    ring_addr_type;
   typedef logic [BARS_W-1:0]     bars_type;
   typedef logic [SUM_W-1:0]      sum_type;
   typedef logic [PER_W-1:0]      period_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [15:0]           count_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   typedef enum logic {
      REG_FAST_PERIOD = 1'b0,
      REG_SLOW_PERIOD = 1'b1
   } reg_index_type;

   // Read request to the close ring: one address per window
   typedef struct packed {
      logic          en;
      ring_addr_type fast_addr;
      ring_addr_type slow_addr;
   } ring_rd_type;

   // Write of one close into the ring
   typedef struct packed {
      logic          en;
      ring_addr_type addr;
      price_type     data;
   } ring_wr_type;

   // Closes leaving the two windows
   typedef struct packed {
      price_type fast;
      price_type slow;
   } ring_dat_type;

endpackage

// ----- hw/rtl/macs_if.sv -----
// ============================================================================
// macs_if
// Request and response channels of the crossover core, each with
// valid/ready handshake and its payload.
// ============================================================================
interface macs_req_if;
   logic      valid;
   logic      ready;
   logic [31:0] open_price;
   logic [31:0] close_price;
   logic      last_bar;

   modport source (output valid, output open_price, output close_price,
                   output last_bar, input ready);
   modport sink   (input valid, input open_price, input close_price,
                   input last_bar, output ready);
endinterface

interface macs_rsp_if;
   logic                 valid;
   logic                 ready;
   macs_pkg::action_type action;
   logic [31:0]          trade_price;
   logic                 position_held;
   logic [15:0]          order_count;
   logic                 liquidated;

   modport source (output valid, output action, output trade_price,
                   output position_held, output order_count, output liquidated,
                   input ready);
   modport sink   (input valid, input action, input trade_price,
                   input position_held, input order_count, input liquidated,
                   output ready);
endinterface

// ----- hw/rtl/macs_ring.sv -----
// ============================================================================
// macs_ring
// Close ring: one write port and two registered read ports. A read that hits
// the entry written at the same edge returns the new close.
// ============================================================================
module macs_ring (
   input  logic                   clock,
   input  macs_pkg::ring_wr_type  wr,
   input  macs_pkg::ring_rd_type  rd,
   output macs_pkg::ring_dat_type dout
);

   macs_pkg::price_type mem [macs_pkg::MAX_WINDOW];

   macs_pkg::price_type fast_ff;
   macs_pkg::price_type slow_ff;

   // Write the incoming close
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read both windows' tails, bypass a same-edge write
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.fast_addr)) begin
            fast_ff <= wr.data;
         end else begin
            fast_ff <= mem[rd.fast_addr];
         end
         if (wr.en && (wr.addr == rd.slow_addr)) begin
            slow_ff <= wr.data;
         end else begin
            slow_ff <= mem[rd.slow_addr];
         end
      end
   end

   assign dout.fast = fast_ff;
   assign dout.slow = slow_ff;

endmodule

// ----- hw/rtl/moving_average_crossover_signal_core.sv -----
// Pipeline: an accepted request is held in stage one, then moves into the response
// register once that register is empty or being taken. Throughput: one request per
// cycle while responses are taken; the first stage issues the ring tail reads, the
// second updates both running sums and writes the ring in the same cycle.
// Reset: synchronous, active high; periods return to 10 and 50, sums, counters
// and position clear. The close ring is not swept; only written entries are used.
// ============================================================================
// moving_average_crossover_signal_core
// Dual simple moving average crossover: running fast and slow sums over a
// ring of closes, buy/sell decisions by cross-multiplied compare, saturating
// order count and end-of-run liquidation.
// ============================================================================
module moving_average_crossover_signal_core (
   input  logic                clock,
   input  logic                reset,
   macs_req_if.sink            req,
   macs_rsp_if.source          rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   function automatic macs_pkg::period_type eff_period(input macs_pkg::period_type p);
      macs_pkg::period_type cap;
      cap = macs_pkg::PER_W'(macs_pkg::PER_CAP_INT);
      if (p == '0) begin
         return macs_pkg::PER_W'(1);
      end else if (p > cap) begin
         return cap;
      end
      return p;
   endfunction

   function automatic macs_pkg::ring_addr_type ring_back(
      input macs_pkg::ring_addr_type slot, input macs_pkg::period_type p);
      logic [macs_pkg::RING_AW:0] s_w;
      logic [macs_pkg::RING_AW:0] p_w;
      logic [macs_pkg::RING_AW:0] r_w;
      s_w = (macs_pkg::RING_AW+1)'(slot);
      p_w = (macs_pkg::RING_AW+1)'(p);
      if (s_w >= p_w) begin
         r_w = s_w - p_w;
      end else begin
         r_w = s_w + (macs_pkg::RING_AW+1)'(macs_pkg::MAX_WINDOW) - p_w;
      end
      return macs_pkg::RING_AW'(r_w);
   endfunction

   function automatic logic bars_reach(input macs_pkg::bars_type b,
                                       input macs_pkg::period_type p);
      return macs_pkg::CMP_W'(b) >= macs_pkg::CMP_W'(p);
   endfunction

   function automatic macs_pkg::count_type sat_inc(input macs_pkg::count_type c,
                                                   input logic inc);
      if (inc && (c != '1)) begin
         return c + 16'd1;
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   macs_pkg::period_type fast_period_ff;
   macs_pkg::period_type slow_period_ff;
   macs_pkg::period_type pf;
   macs_pkg::period_type ps;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write a period register on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= macs_pkg::PER_W'(macs_pkg::FAST_PERIOD_RST);
         slow_period_ff <= macs_pkg::PER_W'(macs_pkg::SLOW_PERIOD_RST);
      end else if (csr_wr) begin
         unique case (macs_pkg::reg_index_type'(csr_paddr[2]))
            macs_pkg::REG_FAST_PERIOD: fast_period_ff <= csr_pwdata[7:0];
            macs_pkg::REG_SLOW_PERIOD: slow_period_ff <= csr_pwdata[7:0];
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (macs_pkg::reg_index_type'(csr_paddr[2]))
         macs_pkg::REG_FAST_PERIOD: csr_prdata = 32'(fast_period_ff);
         macs_pkg::REG_SLOW_PERIOD: csr_prdata = 32'(slow_period_ff);
      endcase
   end

   assign pf = eff_period(fast_period_ff);
   assign ps = eff_period(slow_period_ff);

   // ---------------------------------------------------------------------
   // Handshake and pipeline control
   // ---------------------------------------------------------------------
   logic s1_vld_ff, s1_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic s1_adv;
   logic req_fire;

   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp.ready);
   assign req.ready = !s1_vld_ff || s1_adv;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage one: slot and fill tracking, ring read issue
   // ---------------------------------------------------------------------
   macs_pkg::ring_addr_type slot_ff, slot_in;
   macs_pkg::bars_type      bars_ff, bars_in;
   macs_pkg::ring_rd_type   ring_rd;

   always_comb begin
      slot_in = slot_ff;
      bars_in = bars_ff;
      if (req_fire) begin
         if (req.last_bar) begin
            slot_in = '0;
            bars_in = '0;
         end else begin
            if (slot_ff == macs_pkg::RING_AW'(macs_pkg::MAX_WINDOW - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + macs_pkg::RING_AW'(1);
            end
            if (bars_ff < macs_pkg::BARS_W'(macs_pkg::MAX_WINDOW)) begin
               bars_in = bars_ff + macs_pkg::BARS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         bars_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         bars_ff <= bars_in;
      end
   end

   assign ring_rd.en        = req_fire;
   assign ring_rd.fast_addr = ring_back(slot_ff, pf);
   assign ring_rd.slow_addr = ring_back(slot_ff, ps);

   // Hold the request and its window flags for stage two
   macs_pkg::price_type     s1_open_ff;
   macs_pkg::price_type     s1_close_ff;
   logic                    s1_last_ff;
   macs_pkg::ring_addr_type s1_slot_ff;
   logic                    s1_rm_fast_ff;
   logic                    s1_rm_slow_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_open_ff    <= macs_pkg::PRICE_BITS'(req.open_price);
         s1_close_ff   <= macs_pkg::PRICE_BITS'(req.close_price);
         s1_last_ff    <= req.last_bar;
         s1_slot_ff    <= slot_ff;
         s1_rm_fast_ff <= bars_reach(bars_ff, pf);
         s1_rm_slow_ff <= bars_reach(bars_ff, ps);
      end
   end

   // ---------------------------------------------------------------------
   // Close ring
   // ---------------------------------------------------------------------
   macs_pkg::ring_wr_type  ring_wr;
   macs_pkg::ring_dat_type ring_q;

   assign ring_wr.en   = s1_adv;
   assign ring_wr.addr = s1_slot_ff;
   assign ring_wr.data = s1_close_ff;

   macs_ring u_ring (
      .clock (clock),
      .wr    (ring_wr),
      .rd    (ring_rd),
      .dout  (ring_q)
   );

   // ---------------------------------------------------------------------
   // Stage two: decision on previous sums, sum update, order count
   // ---------------------------------------------------------------------
   macs_pkg::sum_type    fast_sum_ff, fast_sum_in;
   macs_pkg::sum_type    slow_sum_ff, slow_sum_in;
   logic                 inv_ff, inv_in;
   macs_pkg::count_type  orders_ff, orders_in;
   macs_pkg::prod_type   lhs;
   macs_pkg::prod_type   rhs;
   macs_pkg::action_type act;
   logic                 inv_new;
   logic                 liq;
   macs_pkg::count_type  orders_mid;
   macs_pkg::count_type  orders_fin;
   macs_pkg::sum_type    fast_sub;
   macs_pkg::sum_type    slow_sub;

   assign lhs = macs_pkg::PROD_W'(fast_sum_ff) * macs_pkg::PROD_W'(ps);
   assign rhs = macs_pkg::PROD_W'(slow_sum_ff) * macs_pkg::PROD_W'(pf);

   // Decide the trade, then count a liquidation on the last bar
   always_comb begin
      act     = macs_pkg::ACT_NONE;
      inv_new = inv_ff;
      if (s1_rm_fast_ff && s1_rm_slow_ff) begin
         if (!inv_ff && (lhs > rhs)) begin
            act     = macs_pkg::ACT_BUY;
            inv_new = 1'b1;
         end else if (inv_ff && (lhs < rhs)) begin
            act     = macs_pkg::ACT_SELL;
            inv_new = 1'b0;
         end
      end
      liq        = s1_last_ff && inv_new;
      orders_mid = sat_inc(orders_ff, act != macs_pkg::ACT_NONE);
      orders_fin = sat_inc(orders_mid, liq);
   end

   // Slide both windows by this close
   assign fast_sub = s1_rm_fast_ff ? macs_pkg::SUM_W'(ring_q.fast) : '0;
   assign slow_sub = s1_rm_slow_ff ? macs_pkg::SUM_W'(ring_q.slow) : '0;

   always_comb begin
      fast_sum_in = fast_sum_ff;
      slow_sum_in = slow_sum_ff;
      inv_in      = inv_ff;
      orders_in   = orders_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            fast_sum_in = '0;
            slow_sum_in = '0;
            inv_in      = 1'b0;
            orders_in   = '0;
         end else begin
            fast_sum_in = fast_sum_ff + macs_pkg::SUM_W'(s1_close_ff) - fast_sub;
            slow_sum_in = slow_sum_ff + macs_pkg::SUM_W'(s1_close_ff) - slow_sub;
            inv_in      = inv_new;
            orders_in   = orders_fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_sum_ff <= '0;
         slow_sum_ff <= '0;
         inv_ff      <= 1'b0;
         orders_ff   <= '0;
      end else begin
         fast_sum_ff <= fast_sum_in;
         slow_sum_ff <= slow_sum_in;
         inv_ff      <= inv_in;
         orders_ff   <= orders_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   macs_pkg::action_type rsp_action_ff;
   logic [31:0]          rsp_price_ff;
   logic                 rsp_held_ff;
   macs_pkg::count_type  rsp_count_ff;
   logic                 rsp_liq_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_action_ff <= act;
         rsp_price_ff  <= (act != macs_pkg::ACT_NONE) ? 32'(s1_open_ff) : 32'd0;
         rsp_held_ff   <= inv_new;
         rsp_count_ff  <= orders_fin;
         rsp_liq_ff    <= liq;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.action        = rsp_action_ff;
   assign rsp.trade_price   = rsp_price_ff;
   assign rsp.position_held = rsp_held_ff;
   assign rsp.order_count   = rsp_count_ff;
   assign rsp.liquidated    = rsp_liq_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_buy_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.action == macs_pkg::ACT_BUY)) |-> rsp.position_held)
      else $error("buy response without a held position");

   a_sell_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.action == macs_pkg::ACT_SELL)) |-> !rsp.position_held)
      else $error("sell response with a held position");

   a_liq_held: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.liquidated) |-> rsp.position_held)
      else $error("liquidation without a held position");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.last_bar) |=> ((slot_ff == '0) && (bars_ff == '0)))
      else $error("ring slot or fill count not cleared after last bar");

   a_ring_order: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (s1_vld_ff && (s1_slot_ff == $past(slot_ff))))
      else $error("stage two lost the slot of an accepted request");

endmodule
